// ----- src/assert_macros.svh -----
// Assertion helpers for the checker file bfd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define BFD_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define BFD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

// ----- src/bfd_pkg.sv -----
// ----------------------------------------------------------------------------
// bfd_pkg: shared types and constants of the byte frame deframer
// Payload structs, queue entry, configuration image and code constants.
// ----------------------------------------------------------------------------
`default_nettype none

package bfd_pkg;

    // Header match depth supported by the hunt logic.
    localparam int HEADER_MAX = 4;
    localparam logic [2:0] HDR_LIMIT = (HEADER_MAX < 4) ? 3'(HEADER_MAX) : 3'd4;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_BYTES   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_LENGTH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_FIELD   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIXED_LENGTH   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAIL_BYTE      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAIL_ON        = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_MODE     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY       = 3'd7;

    // Check modes.
    localparam logic [2:0] CHK_NONE   = 3'd0;
    localparam logic [2:0] CHK_XOR    = 3'd1;
    localparam logic [2:0] CHK_SUM8   = 3'd2;
    localparam logic [2:0] CHK_CRC8   = 3'd3;
    localparam logic [2:0] CHK_MODBUS = 3'd4;
    localparam logic [2:0] CHK_CCITT  = 3'd5;

    // Error kinds.
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_LENGTH = 2'd1;
    localparam logic [1:0] ERR_CHECK  = 2'd2;
    localparam logic [1:0] ERR_TAIL   = 2'd3;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_index;
        logic [7:0]  payload_byte;
        logic        payload_stored;
        logic        frame_done;
        logic [7:0]  frame_length;
        logic [1:0]  error_kind;
        logic [31:0] frames_total;
        logic [31:0] errors_total;
    } out_item_t;

    typedef struct packed {
        logic [31:0] header_bytes;
        logic [2:0]  header_length;
        logic        length_field_on;
        logic [7:0]  fixed_payload_length;
        logic [7:0]  tail_byte;
        logic        tail_on;
        logic [2:0]  check_mode;
        logic [7:0]  payload_capacity;
    } cfg_t;

    // Byte as classified by the front end.
    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
        logic       hdr0_hit;   // equals first header byte
        logic       tail_hit;   // equals tail byte
        logic       len_over;   // rejected as a length byte
    } qitem_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

endpackage

`default_nettype wire

// ----- src/bfd_front.sv -----
// ----------------------------------------------------------------------------
// bfd_front: input acceptance and byte classification
// Takes input transfers while the queue has room and tags each byte with
// the comparisons that depend on configuration only.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_front (
    input  wire                   s_valid,
    output logic                  s_ready,
    input  bfd_pkg::in_item_t     s_data,
    input  bfd_pkg::cfg_t         cfg,
    input  bfd_pkg::q_status_t    q_status,
    output logic                  push,
    output bfd_pkg::qitem_t       push_item
);

    assign s_ready = !q_status.full;
    assign push    = s_valid && !q_status.full;

    always_comb begin
        push_item.command  = s_data.command;
        push_item.rx_byte  = s_data.rx_byte;
        push_item.hdr0_hit = (s_data.rx_byte == cfg.header_bytes[7:0]);
        push_item.tail_hit = (s_data.rx_byte == cfg.tail_byte);
        push_item.len_over = (cfg.payload_capacity == 8'd0) ||
                             (s_data.rx_byte > cfg.payload_capacity);
    end

endmodule

`default_nettype wire

// ----- src/bfd_queue.sv -----
// ----------------------------------------------------------------------------
// bfd_queue: two-entry queue between front end and frame engine
// Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_queue (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   push,
    input  bfd_pkg::qitem_t       push_item,
    input  wire                   pop,
    output bfd_pkg::q_status_t    q_status,
    output bfd_pkg::qitem_t       head
);

    bfd_pkg::qitem_t mem_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head           = mem_reg[rd_ptr_reg];
    assign q_status.valid = (count_reg != 2'd0);
    assign q_status.full  = (count_reg == 2'd2);

endmodule

`default_nettype wire

// ----- src/bfd_engine.sv -----
// ----------------------------------------------------------------------------
// bfd_engine: frame state machine and result register
// Hunt, length, payload, check and tail; one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_engine #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  bfd_pkg::cfg_t         cfg,
    input  bfd_pkg::q_status_t    q_status,
    input  bfd_pkg::qitem_t       q_item,
    output logic                  pop,
    output logic                  m_valid,
    input  wire                   m_ready,
    output bfd_pkg::out_item_t    m_data
);

    localparam logic [7:0]  CRC8_POLY   = 8'h07;
    localparam logic [15:0] MODBUS_POLY = 16'hA001;
    localparam logic [15:0] CCITT_POLY  = 16'h1021;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN,
        PH_PAY,
        PH_CHECK,
        PH_TAIL
    } phase_t;

    function automatic logic [15:0] acc_step(input logic [2:0] mode,
                                             input logic [15:0] acc,
                                             input logic [7:0] b);
        logic [15:0] a;
        a = acc;
        case (mode)
            bfd_pkg::CHK_XOR:  a = {8'h00, acc[7:0] ^ b};
            bfd_pkg::CHK_SUM8: a = {8'h00, acc[7:0] + b};
            bfd_pkg::CHK_CRC8: begin
                a = {8'h00, acc[7:0] ^ b};
                for (int i = 0; i < 8; i++) begin
                    a[7:0] = a[7] ? ({a[6:0], 1'b0} ^ CRC8_POLY) : {a[6:0], 1'b0};
                end
            end
            bfd_pkg::CHK_MODBUS: begin
                a = acc ^ {8'h00, b};
                for (int i = 0; i < 8; i++) begin
                    a = a[0] ? ((a >> 1) ^ MODBUS_POLY) : (a >> 1);
                end
            end
            bfd_pkg::CHK_CCITT: begin
                a = acc ^ {b, 8'h00};
                for (int i = 0; i < 8; i++) begin
                    a = a[15] ? ({a[14:0], 1'b0} ^ CCITT_POLY) : {a[14:0], 1'b0};
                end
            end
            default: a = acc;
        endcase
        return a;
    endfunction

    function automatic logic check_good(input logic [2:0] mode, input logic [15:0] acc,
                                        input logic [7:0] c0, input logic [7:0] c1);
        logic good;
        case (mode)
            bfd_pkg::CHK_XOR, bfd_pkg::CHK_SUM8, bfd_pkg::CHK_CRC8:
                good = (c0 == acc[7:0]);
            bfd_pkg::CHK_MODBUS: good = (c0 == acc[7:0]) && (c1 == acc[15:8]);
            bfd_pkg::CHK_CCITT:  good = (c0 == acc[15:8]) && (c1 == acc[7:0]);
            default:             good = 1'b1;
        endcase
        return good;
    endfunction

    phase_t                   phase_reg, phase_next;
    logic [2:0]               hm_reg, hm_next;
    logic [7:0]               el_reg, el_next;
    logic [7:0]               rc_reg, rc_next;
    logic [1:0]               cs_reg, cs_next;
    logic [7:0]               cb0_reg, cb0_next;
    logic [7:0]               cb1_reg, cb1_next;
    logic [15:0]              acc_reg, acc_next;
    logic [COUNT_WIDTH-1:0]   frames_reg, frames_next;
    logic [COUNT_WIDTH-1:0]   errors_reg, errors_next;
    logic                     m_valid_reg, m_valid_next;
    bfd_pkg::out_item_t       m_data_reg, res;

    logic                     step;
    logic [2:0]               hlen;
    logic [1:0]               csize;
    logic [15:0]              acc_init;
    logic [7:0]               want;
    logic [7:0]               b;
    logic                     after_pay, done, rej, go_hunt;
    logic [1:0]               kind;

    assign step = q_status.valid && (!m_valid_reg || m_ready);
    assign pop  = step;
    assign b    = q_item.rx_byte;
    assign want = cfg.header_bytes[{hm_reg[1:0], 3'b000} +: 8];

    always_comb begin
        hlen = cfg.header_length;
        if (hlen == 3'd0) begin
            hlen = 3'd1;
        end
        if (hlen > bfd_pkg::HDR_LIMIT) begin
            hlen = bfd_pkg::HDR_LIMIT;
        end
    end

    always_comb begin
        case (cfg.check_mode)
            bfd_pkg::CHK_XOR, bfd_pkg::CHK_SUM8, bfd_pkg::CHK_CRC8: csize = 2'd1;
            bfd_pkg::CHK_MODBUS, bfd_pkg::CHK_CCITT:             csize = 2'd2;
            default:                                             csize = 2'd0;
        endcase
        acc_init = (csize == 2'd2) ? 16'hFFFF : 16'h0000;
    end

    always_comb begin
        phase_next  = phase_reg;
        hm_next     = hm_reg;
        el_next     = el_reg;
        rc_next     = rc_reg;
        cs_next     = cs_reg;
        cb0_next    = cb0_reg;
        cb1_next    = cb1_reg;
        acc_next    = acc_reg;
        frames_next = frames_reg;
        errors_next = errors_reg;
        after_pay   = 1'b0;
        done        = 1'b0;
        rej         = 1'b0;
        go_hunt     = 1'b0;
        kind        = bfd_pkg::ERR_NONE;
        res         = '0;

        if (q_item.command) begin
            go_hunt = 1'b1;
        end else begin
            case (phase_reg)
                PH_HUNT: begin
                    if (b == want) begin
                        hm_next = hm_reg + 3'd1;
                        if (hm_next >= hlen) begin
                            acc_next = acc_init;
                            if (cfg.length_field_on) begin
                                phase_next = PH_LEN;
                            end else begin
                                el_next = cfg.fixed_payload_length;
                                rc_next = 8'd0;
                                if (el_next == 8'd0) begin
                                    after_pay = 1'b1;
                                end else begin
                                    phase_next = PH_PAY;
                                end
                            end
                        end
                    end else if (hm_reg != 3'd0 && q_item.hdr0_hit) begin
                        hm_next = 3'd1;
                    end else begin
                        hm_next = 3'd0;
                    end
                end
                PH_LEN: begin
                    el_next  = b;
                    acc_next = acc_step(cfg.check_mode, acc_reg, b);
                    if (q_item.len_over) begin
                        rej  = 1'b1;
                        kind = bfd_pkg::ERR_LENGTH;
                    end else begin
                        rc_next = 8'd0;
                        if (b == 8'd0) begin
                            after_pay = 1'b1;
                        end else begin
                            phase_next = PH_PAY;
                        end
                    end
                end
                PH_PAY: begin
                    acc_next           = acc_step(cfg.check_mode, acc_reg, b);
                    res.payload_valid  = 1'b1;
                    res.payload_index  = rc_reg;
                    res.payload_byte   = b;
                    res.payload_stored = (rc_reg < cfg.payload_capacity);
                    rc_next            = rc_reg + 8'd1;
                    if (rc_next >= el_reg) begin
                        after_pay = 1'b1;
                    end
                end
                PH_CHECK: begin
                    if (cs_reg[0]) begin
                        cb1_next = b;
                    end else begin
                        cb0_next = b;
                    end
                    cs_next = cs_reg + 2'd1;
                    if (cs_next >= csize) begin
                        if (check_good(cfg.check_mode, acc_reg, cb0_next, cb1_next)) begin
                            if (cfg.tail_on) begin
                                phase_next = PH_TAIL;
                            end else begin
                                done = 1'b1;
                            end
                        end else begin
                            rej  = 1'b1;
                            kind = bfd_pkg::ERR_CHECK;
                        end
                    end
                end
                PH_TAIL: begin
                    if (q_item.tail_hit) begin
                        done = 1'b1;
                    end else begin
                        rej  = 1'b1;
                        kind = bfd_pkg::ERR_TAIL;
                    end
                end
                default: begin
                    go_hunt = 1'b1;
                end
            endcase
        end

        if (after_pay) begin
            if (csize == 2'd0) begin
                if (cfg.tail_on) begin
                    phase_next = PH_TAIL;
                end else begin
                    done = 1'b1;
                end
            end else begin
                phase_next = PH_CHECK;
                cs_next    = 2'd0;
            end
        end
        if (done) begin
            res.frame_done   = 1'b1;
            res.frame_length = rc_next;
            frames_next      = frames_reg + COUNT_WIDTH'(1);
            go_hunt          = 1'b1;
        end
        if (rej) begin
            res.error_kind = kind;
            errors_next    = errors_reg + COUNT_WIDTH'(1);
            go_hunt        = 1'b1;
        end
        if (go_hunt) begin
            phase_next = PH_HUNT;
            hm_next    = 3'd0;
            el_next    = 8'd0;
            rc_next    = 8'd0;
            cs_next    = 2'd0;
        end
        res.frames_total = 32'(frames_next);
        res.errors_total = 32'(errors_next);
    end

    always_comb begin
        if (step) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            hm_reg      <= 3'd0;
            el_reg      <= 8'd0;
            rc_reg      <= 8'd0;
            cs_reg      <= 2'd0;
            cb0_reg     <= 8'd0;
            cb1_reg     <= 8'd0;
            acc_reg     <= 16'h0000;
            frames_reg  <= '0;
            errors_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (step) begin
                phase_reg  <= phase_next;
                hm_reg     <= hm_next;
                el_reg     <= el_next;
                rc_reg     <= rc_next;
                cs_reg     <= cs_next;
                cb0_reg    <= cb0_next;
                cb1_reg    <= cb1_next;
                acc_reg    <= acc_next;
                frames_reg <= frames_next;
                errors_reg <= errors_next;
            end
        end
        if (step) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ----- src/byte_frame_deframer_with_check.sv -----
// ----------------------------------------------------------------------------
// byte_frame_deframer_with_check: byte stream deframer with frame check
// Header hunt, length byte or fixed length, payload emission, check bytes
// and optional tail, with wrapping frame and error counters.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one received byte (or a resync command) per
//   transfer. m_valid/m_ready/m_data return exactly one result per input
//   transfer: payload byte info, frame completion, error kind and counters.
//   cfg_wr_en/cfg_index/cfg_wr_data write one configuration register per
//   cycle; write only while no transfer is in flight.
//   Path: a byte taken is stored in the queue and then, when the engine
//   steps, in the result register, where its result becomes valid.
//   Throughput: one byte per cycle while the result is empty or taken,
//   with the check update unrolled over the eight bit steps.
//   Reset (aresetn low, synchronous) puts the engine in header hunt, clears
//   counters, check state and queue, and loads register reset values.
//   Receiver stall: the result register holds; the two-entry queue keeps
//   taking bytes until it fills, then s_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_frame_deframer_with_check #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    // byte input
    input  wire                   s_valid,
    output logic                  s_ready,
    input  bfd_pkg::in_item_t     s_data,
    // results
    output logic                  m_valid,
    input  wire                   m_ready,
    output bfd_pkg::out_item_t    m_data,
    // configuration writes
    input  wire                   cfg_wr_en,
    input  wire [bfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire [31:0]            cfg_wr_data
);

    // Configuration image. The user keeps it stable while bytes are in flight;
    // unenforced; the front end may classify before the engine sees the byte.
    bfd_pkg::cfg_t      cfg_reg, cfg_next;

    bfd_pkg::q_status_t q_status;
    bfd_pkg::qitem_t    push_item;
    bfd_pkg::qitem_t    head;
    logic               push;
    logic               pop;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                bfd_pkg::CFG_HEADER_BYTES:  cfg_next.header_bytes = cfg_wr_data;
                bfd_pkg::CFG_HEADER_LENGTH: cfg_next.header_length = cfg_wr_data[2:0];
                bfd_pkg::CFG_LENGTH_FIELD:  cfg_next.length_field_on = cfg_wr_data[0];
                bfd_pkg::CFG_FIXED_LENGTH:  cfg_next.fixed_payload_length = cfg_wr_data[7:0];
                bfd_pkg::CFG_TAIL_BYTE:     cfg_next.tail_byte = cfg_wr_data[7:0];
                bfd_pkg::CFG_TAIL_ON:       cfg_next.tail_on = cfg_wr_data[0];
                bfd_pkg::CFG_CHECK_MODE:    cfg_next.check_mode = cfg_wr_data[2:0];
                bfd_pkg::CFG_CAPACITY:      cfg_next.payload_capacity = cfg_wr_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_bytes         <= 32'h0000_0000;
            cfg_reg.header_length        <= 3'd1;
            cfg_reg.length_field_on      <= 1'b1;
            cfg_reg.fixed_payload_length <= 8'd0;
            cfg_reg.tail_byte            <= 8'd0;
            cfg_reg.tail_on              <= 1'b0;
            cfg_reg.check_mode           <= bfd_pkg::CHK_NONE;
            cfg_reg.payload_capacity     <= 8'd255;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: accepts transfers and tags each byte.
    bfd_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    // Decoupling queue: lets input keep flowing while the result is stalled.
    bfd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .q_status  (q_status),
        .head      (head)
    );

    // Back end: frame FSM; one byte per cycle into result reg unless stalled.
    bfd_engine #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .q_item   (head),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

// ----- src/bfd_checker.sv -----
// ----------------------------------------------------------------------------
// bfd_checker: port-level assertions for the deframer
// Watches the result channel; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bfd_checker (
    input wire                aclk,
    input wire                aresetn,
    input wire                m_valid,
    input wire                m_ready,
    input bfd_pkg::out_item_t m_data
);

    logic stalled;
    logic done_err;
    logic stray_payload;

    assign stalled       = m_valid && !m_ready;
    assign done_err      = m_data.frame_done && (m_data.error_kind != bfd_pkg::ERR_NONE);
    assign stray_payload = !m_data.payload_valid &&
                           ((m_data.payload_index != 8'd0) || (m_data.payload_byte != 8'd0) ||
                            m_data.payload_stored);

    // No result may survive a reset edge.
    `BFD_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_valid, "result valid after reset")

    // A stalled result stays put.
    `BFD_ASSERT_RUN(a_stall_hold, stalled |=> m_valid && $stable(m_data), "stalled result changed")

    // A finished frame carries no error; the last payload byte may close it.
    `BFD_ASSERT_RUN(a_done_clean, m_valid |-> !done_err, "frame done with error")

    // Payload fields are zero when no payload byte is reported.
    `BFD_ASSERT_RUN(a_payload_zero, m_valid |-> !stray_payload, "stray payload fields")

endmodule

bind byte_frame_deframer_with_check bfd_checker u_bfd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
